// ----- hdl/plt_pkg.sv -----
// ----------------------------------------------------------------------------
// plt_pkg
// shared constants, command/status structs and controller states for the
// pairwise linkage statistics unit
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int MAX_GENES  = 32;
   localparam int POP_BITS   = 16;
   localparam int ETB        = 12;

   localparam int GENE_W     = 16;
   localparam int PS_W       = 6;
   localparam int IDX_W      = $clog2(MAX_GENES);
   localparam int PAIRS      = (MAX_GENES * (MAX_GENES - 1)) / 2;
   localparam int SLOT_W     = $clog2(PAIRS);
   localparam int CNT_W      = POP_BITS;
   localparam int ADJ_W      = 32 + POP_BITS;
   localparam int STAT_W     = CNT_W + ADJ_W;
   localparam int Q_W        = 17;
   localparam int Q_ONE      = 65536;
   localparam int DIV_W      = 16 + POP_BITS;
   localparam int DCNT_W     = $clog2(DIV_W);
   localparam int ENT_N      = 1 << ETB;
   localparam int TOP_W      = $clog2(ETB);
   localparam int FRAC_W     = 16;
   localparam int LCNT_W     = $clog2(FRAC_W);
   localparam int LOG_W      = FRAC_W + TOP_W;
   localparam int M_W        = 31;
   localparam int PROD_W     = ETB + LOG_W;
   localparam int S_W        = PROD_W - ETB + 1;
   localparam int ENT_WHOLE  = ETB * Q_ONE;

   localparam logic OP_GENE  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_LATCH,
      ST_ABS_RD,
      ST_ABS_CALC,
      ST_ABS_WR,
      ST_REB_RD,
      ST_REB_GO,
      ST_DIVK,
      ST_DIVA,
      ST_LOGK,
      ST_LOGNK,
      ST_PROD,
      ST_ENT,
      ST_DEP,
      ST_REB_WR,
      ST_Q_RD,
      ST_Q_OUT
   } state_type;

   typedef struct packed {
      logic clr_wr;
      logic gene_wr;
      logic pair_init;
      logic pair_next;
      logic row_rd;
      logic row_latch;
      logic abs_calc;
      logic abs_wr;
      logic div_start;
      logic div_sel_adj;
      logic k_latch;
      logic a_latch;
      logic log_start;
      logic log_sel_nk;
      logic lk_latch;
      logic lnk_latch;
      logic prod_calc;
      logic ent_calc;
      logic dep_calc;
      logic dist_wr;
      logic ready_set;
      logic q_latch;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic row_last;
      logic pair_last;
      logic pop_multi;
      logic div_done;
      logic log_done;
      logic rsp_free;
   } status_type;

endpackage

// ----- hdl/plt_ram.sv -----
// ----------------------------------------------------------------------------
// plt_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module plt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/plt_div.sv -----
// ----------------------------------------------------------------------------
// plt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module plt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [plt_pkg::DIV_W-1:0]     dividend,
   input  logic [plt_pkg::POP_BITS-1:0]  divisor,
   output logic                          done,
   output logic [plt_pkg::DIV_W-1:0]     quotient
);
   import plt_pkg::*;

   logic [POP_BITS-1:0] rem_ff;
   logic [POP_BITS-1:0] den_ff;
   logic [DIV_W-1:0]    quo_ff;
   logic [DCNT_W-1:0]   cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [POP_BITS:0]   shifted;
   logic [POP_BITS:0]   diff;
   logic                fits;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         den_ff <= divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[POP_BITS-1:0] : shifted[POP_BITS-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/plt_log.sv -----
// ----------------------------------------------------------------------------
// plt_log
// base-2 logarithm in q.16, one fraction bit per cycle by repeated squaring
// ----------------------------------------------------------------------------
module plt_log (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [plt_pkg::ETB-1:0]    x,
   output logic                       done,
   output logic [plt_pkg::LOG_W-1:0]  result
);
   import plt_pkg::*;

   logic [M_W-1:0]     m_ff;
   logic [TOP_W-1:0]   top_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [LCNT_W-1:0]  cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [TOP_W-1:0]   top;
   logic [M_W-1:0]     m_start;
   logic [2*M_W-1:0]   sq;
   logic [M_W:0]       t;

   always_comb begin
      top = '0;
      for (int b = 0; b < ETB; b++) begin
         if (x[b]) begin
            top = TOP_W'(b);
         end
      end
      m_start = M_W'(x) << (M_W - 1 - int'(top));
   end

   assign sq = (2*M_W)'(m_ff) * (2*M_W)'(m_ff);
   assign t  = sq[2*M_W-1:M_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == LCNT_W'(FRAC_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         m_ff    <= m_start;
         top_ff  <= top;
         frac_ff <= '0;
      end else if (busy_ff) begin
         m_ff    <= t[M_W] ? t[M_W:1] : t[M_W-1:0];
         frac_ff <= {frac_ff[FRAC_W-2:0], t[M_W]};
      end
   end

   assign done   = done_ff;
   assign result = {top_ff, frac_ff};

endmodule

// ----- hdl/plt_dp.sv -----
// ----------------------------------------------------------------------------
// plt_dp
// datapath: gene buffer, pair statistics, distance store, arithmetic units
// ----------------------------------------------------------------------------
module plt_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  plt_pkg::cmd_type               cmd,
   input  logic [plt_pkg::GENE_W-1:0]     req_gene_value,
   input  logic [plt_pkg::POP_BITS-1:0]   req_population_size,
   input  logic [plt_pkg::IDX_W-1:0]      req_first_gene,
   input  logic [plt_pkg::IDX_W-1:0]      req_second_gene,
   input  logic                           csr_valid,
   input  logic [plt_pkg::PS_W-1:0]       csr_problem_size,
   input  logic                           rsp_stall,
   output plt_pkg::status_type            status,
   output logic                           rsp_valid,
   output logic [plt_pkg::Q_W-1:0]        rsp_distance,
   output logic                           rsp_distance_valid
);
   import plt_pkg::*;

   logic [PS_W-1:0]     problem_size_ff;
   logic [PS_W-1:0]     ps_eff;
   logic [PS_W-1:0]     gc_ff;
   logic [IDX_W-1:0]    i_ff;
   logic [IDX_W-1:0]    j_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [POP_BITS-1:0] pop_ff;
   logic [GENE_W-1:0]   gj_ff;
   logic                lt_ff;
   logic [2*GENE_W-1:0] d2_ff;
   logic [ETB:0]        k_ff;
   logic [Q_W-1:0]      adj_ff;
   logic [LOG_W-1:0]    lk_ff;
   logic [LOG_W-1:0]    lnk_ff;
   logic [PROD_W-1:0]   p1_ff;
   logic [PROD_W-1:0]   p2_ff;
   logic [Q_W-1:0]      ordm_ff;
   logic [Q_W-1:0]      dep_ff;
   logic [SLOT_W-1:0]   q_slot_ff;
   logic                q_ok_ff;
   logic                ready_ff;
   logic                rsp_valid_ff;
   logic [Q_W-1:0]      rsp_distance_ff;
   logic                rsp_distance_valid_ff;

   logic                gene_we;
   logic [IDX_W-1:0]    gene_raddr;
   logic [GENE_W-1:0]   gene_rd;
   logic [STAT_W-1:0]   stats_rd;
   logic [STAT_W-1:0]   stats_wdata;
   logic [CNT_W-1:0]    cnt_rd;
   logic [ADJ_W-1:0]    adj_rd;
   logic [CNT_W-1:0]    cnt_new;
   logic [ADJ_W:0]      adj_sum;
   logic [ADJ_W-1:0]    adj_new;
   logic [Q_W-1:0]      dist_rd;
   logic [Q_W-1:0]      dist_new;
   logic [GENE_W-1:0]   gdiff;
   logic [DIV_W-1:0]    div_dividend;
   logic [DIV_W-1:0]    div_q;
   logic                div_done;
   logic [ETB:0]        nk;
   logic [ETB-1:0]      log_x;
   logic [LOG_W-1:0]    log_res;
   logic                log_done;
   logic [PROD_W:0]     psum;
   logic [S_W-1:0]      s_val;
   logic [S_W-1:0]      ent_diff;
   logic [Q_W-1:0]      h_val;
   logic [2*Q_W-1:0]    dep_prod;
   logic [IDX_W-1:0]    q_lo;
   logic [IDX_W-1:0]    q_hi;
   logic [2*IDX_W-1:0]  q_hprod;

   always_comb begin
      if (problem_size_ff < PS_W'(2)) begin
         ps_eff = PS_W'(2);
      end else if (problem_size_ff > PS_W'(MAX_GENES)) begin
         ps_eff = PS_W'(MAX_GENES);
      end else begin
         ps_eff = problem_size_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         problem_size_ff <= PS_W'(MAX_GENES);
         gc_ff           <= '0;
         i_ff            <= '0;
         j_ff            <= IDX_W'(1);
         slot_ff         <= '0;
         ready_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid) begin
            problem_size_ff <= csr_problem_size;
         end
         if (gene_we) begin
            gc_ff <= gc_ff + 1'b1;
         end
         if (cmd.clr_wr) begin
            slot_ff <= slot_ff + 1'b1;
         end
         if (cmd.pair_next) begin
            slot_ff <= slot_ff + 1'b1;
            if (status.row_last) begin
               i_ff <= '0;
               j_ff <= j_ff + 1'b1;
            end else begin
               i_ff <= i_ff + 1'b1;
            end
         end
         if (cmd.pair_init) begin
            gc_ff   <= '0;
            i_ff    <= '0;
            j_ff    <= IDX_W'(1);
            slot_ff <= '0;
         end
         if (cmd.ready_set) begin
            ready_ff <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // gene buffer
   assign gene_we    = cmd.gene_wr && (gc_ff < ps_eff);
   assign gene_raddr = cmd.row_rd ? j_ff : i_ff;

   plt_ram #(.WIDTH(GENE_W), .DEPTH(MAX_GENES)) u_gene_ram (
      .clock   (clock),
      .wr_en   (gene_we),
      .wr_addr (gc_ff[IDX_W-1:0]),
      .wr_data (req_gene_value),
      .rd_addr (gene_raddr),
      .rd_data (gene_rd)
   );

   // pair statistics: count above, adjacency sum below
   assign cnt_rd  = stats_rd[STAT_W-1:ADJ_W];
   assign adj_rd  = stats_rd[ADJ_W-1:0];
   assign cnt_new = (lt_ff && (cnt_rd != '1)) ? cnt_rd + 1'b1 : cnt_rd;
   assign adj_sum = {1'b0, adj_rd} + (ADJ_W+1)'(d2_ff);
   assign adj_new = adj_sum[ADJ_W] ? '1 : adj_sum[ADJ_W-1:0];
   assign stats_wdata = cmd.clr_wr ? '0 : {cnt_new, adj_new};

   plt_ram #(.WIDTH(STAT_W), .DEPTH(PAIRS)) u_stats_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_wr || cmd.abs_wr),
      .wr_addr (slot_ff),
      .wr_data (stats_wdata),
      .rd_addr (slot_ff),
      .rd_data (stats_rd)
   );

   assign dist_new = Q_W'(Q_ONE) - dep_ff;

   plt_ram #(.WIDTH(Q_W), .DEPTH(PAIRS)) u_dist_ram (
      .clock   (clock),
      .wr_en   (cmd.dist_wr),
      .wr_addr (slot_ff),
      .wr_data (dist_new),
      .rd_addr (q_slot_ff),
      .rd_data (dist_rd)
   );

   // shared divider and log unit
   assign div_dividend = cmd.div_sel_adj ? adj_rd[ADJ_W-1:ADJ_W-DIV_W]
                                         : DIV_W'({cnt_rd, {ETB{1'b0}}});

   plt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (pop_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign nk    = (ETB+1)'(ENT_N) - k_ff;
   assign log_x = cmd.log_sel_nk ? nk[ETB-1:0] : k_ff[ETB-1:0];

   plt_log u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.log_start),
      .x      (log_x),
      .done   (log_done),
      .result (log_res)
   );

   // entropy and distance
   assign psum     = {1'b0, p1_ff} + {1'b0, p2_ff};
   assign s_val    = psum[PROD_W:ETB];
   assign ent_diff = S_W'(ENT_WHOLE) - s_val;
   assign dep_prod = (2*Q_W)'(ordm_ff) * (2*Q_W)'(Q_W'(Q_ONE) - adj_ff);

   always_comb begin
      if ((k_ff == '0) || k_ff[ETB] || (s_val >= S_W'(ENT_WHOLE))) begin
         h_val = '0;
      end else if (ent_diff > S_W'(Q_ONE)) begin
         h_val = Q_W'(Q_ONE);
      end else begin
         h_val = ent_diff[Q_W-1:0];
      end
   end

   assign gdiff = (gene_rd > gj_ff) ? gene_rd - gj_ff : gj_ff - gene_rd;

   assign q_lo    = (req_first_gene < req_second_gene) ? req_first_gene : req_second_gene;
   assign q_hi    = (req_first_gene < req_second_gene) ? req_second_gene : req_first_gene;
   assign q_hprod = (2*IDX_W)'(q_hi) * (2*IDX_W)'(q_hi - 1'b1);

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.gene_wr) begin
         pop_ff <= req_population_size;
      end
      if (cmd.row_latch) begin
         gj_ff <= gene_rd;
      end
      if (cmd.abs_calc) begin
         lt_ff <= gene_rd < gj_ff;
         d2_ff <= (2*GENE_W)'(gdiff) * (2*GENE_W)'(gdiff);
      end
      if (cmd.k_latch) begin
         k_ff <= (div_q > DIV_W'(ENT_N)) ? (ETB+1)'(ENT_N) : div_q[ETB:0];
      end
      if (cmd.a_latch) begin
         adj_ff <= (div_q > DIV_W'(Q_ONE)) ? Q_W'(Q_ONE) : div_q[Q_W-1:0];
      end
      if (cmd.lk_latch) begin
         lk_ff <= log_res;
      end
      if (cmd.lnk_latch) begin
         lnk_ff <= log_res;
      end
      if (cmd.prod_calc) begin
         p1_ff <= PROD_W'(k_ff[ETB-1:0]) * PROD_W'(lk_ff);
         p2_ff <= PROD_W'(nk[ETB-1:0]) * PROD_W'(lnk_ff);
      end
      if (cmd.ent_calc) begin
         ordm_ff <= Q_W'(Q_ONE) - h_val;
      end
      if (cmd.dep_calc) begin
         dep_ff <= dep_prod[Q_W+15:16];
      end
      if (cmd.q_latch) begin
         q_slot_ff <= SLOT_W'(q_hprod >> 1) + SLOT_W'(q_lo);
         q_ok_ff   <= ready_ff && (q_lo != q_hi) && ({1'b0, q_hi} < ps_eff);
      end
      if (cmd.rsp_load) begin
         rsp_distance_ff       <= q_ok_ff ? dist_rd : '0;
         rsp_distance_valid_ff <= q_ok_ff;
      end
   end

   assign status.clr_last  = slot_ff == SLOT_W'(PAIRS - 1);
   assign status.row_last  = (i_ff + 1'b1) == j_ff;
   assign status.pair_last = status.row_last && ((PS_W'(j_ff) + 1'b1) == ps_eff);
   assign status.pop_multi = pop_ff > POP_BITS'(1);
   assign status.div_done  = div_done;
   assign status.log_done  = log_done;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_distance_valid = rsp_distance_valid_ff;

endmodule

// ----- hdl/plt_ctrl.sv -----
// ----------------------------------------------------------------------------
// plt_ctrl
// controller: clearing pass, solution absorb sweep, distance rebuild, query
// ----------------------------------------------------------------------------
module plt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_operation,
   input  logic                 req_last_gene,
   input  plt_pkg::status_type  status,
   output logic                 req_stall,
   output plt_pkg::cmd_type     cmd
);
   import plt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_QUERY) begin
                  cmd.q_latch = 1'b1;
                  state_in    = ST_Q_RD;
               end else begin
                  cmd.gene_wr = 1'b1;
                  if (req_last_gene) begin
                     cmd.pair_init = 1'b1;
                     state_in      = ST_ROW_RD;
                  end
               end
            end
         end
         ST_ROW_RD: begin
            cmd.row_rd = 1'b1;
            state_in   = ST_ROW_LATCH;
         end
         ST_ROW_LATCH: begin
            cmd.row_latch = 1'b1;
            state_in      = ST_ABS_RD;
         end
         ST_ABS_RD: begin
            state_in = ST_ABS_CALC;
         end
         ST_ABS_CALC: begin
            cmd.abs_calc = 1'b1;
            state_in     = ST_ABS_WR;
         end
         ST_ABS_WR: begin
            cmd.abs_wr = 1'b1;
            if (status.pair_last) begin
               if (status.pop_multi) begin
                  cmd.pair_init = 1'b1;
                  state_in      = ST_REB_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               cmd.pair_next = 1'b1;
               state_in      = status.row_last ? ST_ROW_RD : ST_ABS_RD;
            end
         end
         ST_REB_RD: begin
            state_in = ST_REB_GO;
         end
         ST_REB_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVK;
         end
         ST_DIVK: begin
            if (status.div_done) begin
               cmd.k_latch     = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_sel_adj = 1'b1;
               state_in        = ST_DIVA;
            end
         end
         ST_DIVA: begin
            if (status.div_done) begin
               cmd.a_latch   = 1'b1;
               cmd.log_start = 1'b1;
               state_in      = ST_LOGK;
            end
         end
         ST_LOGK: begin
            if (status.log_done) begin
               cmd.lk_latch   = 1'b1;
               cmd.log_start  = 1'b1;
               cmd.log_sel_nk = 1'b1;
               state_in       = ST_LOGNK;
            end
         end
         ST_LOGNK: begin
            if (status.log_done) begin
               cmd.lnk_latch = 1'b1;
               state_in      = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod_calc = 1'b1;
            state_in      = ST_ENT;
         end
         ST_ENT: begin
            cmd.ent_calc = 1'b1;
            state_in     = ST_DEP;
         end
         ST_DEP: begin
            cmd.dep_calc = 1'b1;
            state_in     = ST_REB_WR;
         end
         ST_REB_WR: begin
            cmd.dist_wr = 1'b1;
            if (status.pair_last) begin
               cmd.ready_set = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.pair_next = 1'b1;
               state_in      = ST_REB_RD;
            end
         end
         ST_Q_RD: begin
            state_in = ST_Q_OUT;
         end
         ST_Q_OUT: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/pairwise_linkage_statistics_unit.sv -----
// ----------------------------------------------------------------------------
// pairwise_linkage_statistics_unit
// gathers pairwise ordering and adjacency statistics over random-key
// solutions and serves linkage distance queries
// ----------------------------------------------------------------------------
// After reset the unit runs a clearing pass over the 496-entry statistics
// memory with req_stall high; configuration writes are taken throughout.
// The final gene of a solution starts an absorb sweep (ST_ROW_RD and
// ST_ROW_LATCH per row, ST_ABS_RD, ST_ABS_CALC and ST_ABS_WR per gene pair)
// and, with a population above one, a rebuild of every pair through two
// 32-step divisions in the shared divider and two 16-step logarithms in the
// shared log unit. A query reads the registered distance memory; its
// response waits in an output register.
// ----------------------------------------------------------------------------
module pairwise_linkage_statistics_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [plt_pkg::GENE_W-1:0]     req_gene_value,
   input  logic                           req_last_gene,
   input  logic [plt_pkg::POP_BITS-1:0]   req_population_size,
   input  logic [plt_pkg::IDX_W-1:0]      req_first_gene,
   input  logic [plt_pkg::IDX_W-1:0]      req_second_gene,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [plt_pkg::Q_W-1:0]        rsp_distance,
   output logic                           rsp_distance_valid,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [plt_pkg::PS_W-1:0]       csr_problem_size
);
   import plt_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   plt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_last_gene (req_last_gene),
      .status        (status),
      .req_stall     (req_stall),
      .cmd           (cmd)
   );

   plt_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_gene_value      (req_gene_value),
      .req_population_size (req_population_size),
      .req_first_gene      (req_first_gene),
      .req_second_gene     (req_second_gene),
      .csr_valid           (csr_valid && csr_ready),
      .csr_problem_size    (csr_problem_size),
      .rsp_stall           (rsp_stall),
      .status              (status),
      .rsp_valid           (rsp_valid),
      .rsp_distance        (rsp_distance),
      .rsp_distance_valid  (rsp_distance_valid)
   );

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_distance_valid) |-> (rsp_distance == '0))
      else $error("invalid response with nonzero distance");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.rsp_load))
      else $error("response beat without a query");

   a_stats_write_src: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_wr, cmd.abs_wr, cmd.gene_wr}))
      else $error("conflicting statistics writes");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_operation == OP_QUERY)) |=> req_stall)
      else $error("query accepted without going busy");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives gene solutions and distance queries into the pairwise linkage
// statistics unit, predicts every query response from a local model of the
// ordering counts, adjacency sums and rebuilt distances, and compares each
// response beat field by field across several problem sizes and idle mixes
// ----------------------------------------------------------------------------
module tb;
   import plt_pkg::*;

   typedef struct {
      logic             op;
      logic [15:0]      gene;
      logic             last;
      logic [15:0]      pop;
      logic [4:0]       a;
      logic [4:0]       b;
      logic             fixed;
      logic [Q_W-1:0]   fdist;
      logic             fvalid;
   } stim_row_type;

   typedef struct {
      logic [Q_W-1:0] distance;
      logic           valid;
   } dist_rsp_type;

   logic clock, reset;
   logic req_valid, req_stall, req_operation, req_last_gene;
   logic [15:0] req_gene_value, req_population_size;
   logic [4:0] req_first_gene, req_second_gene;
   logic rsp_valid, rsp_stall, rsp_distance_valid;
   logic [Q_W-1:0] rsp_distance;
   logic csr_valid, csr_ready;
   logic [PS_W-1:0] csr_problem_size;

   pairwise_linkage_statistics_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_gene_value(req_gene_value),
      .req_last_gene(req_last_gene), .req_population_size(req_population_size),
      .req_first_gene(req_first_gene), .req_second_gene(req_second_gene),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance), .rsp_distance_valid(rsp_distance_valid),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_problem_size(csr_problem_size)
   );

   // model state
   logic [PS_W-1:0]   size_reg;
   logic [15:0]       genes [MAX_GENES];
   logic [MAX_GENES-1:0] genes_seen;
   int unsigned       gene_cnt;
   int unsigned       order_cnt [PAIRS];
   longint unsigned   adj_sum [PAIRS];
   logic [Q_W-1:0]    pair_dist [PAIRS];
   logic              dist_built [PAIRS];
   logic              dists_ready;

   dist_rsp_type pending_distances [$];
   stim_row_type rows [$];
   int  send_idle, recv_idle;
   bit  failed;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned active_genes();
      if (size_reg < 2) return 2;
      if (size_reg > MAX_GENES) return MAX_GENES;
      return size_reg;
   endfunction

   function automatic int unsigned slot_of(int unsigned lo, int unsigned hi);
      return (hi * (hi - 1)) / 2 + lo;
   endfunction

   function automatic bit genes_filled(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (!genes_seen[i]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void add_row(stim_row_type r);
      rows.insert(rows.size(), r);
   endfunction

   function automatic longint unsigned log2_fix(longint unsigned x);
      int unsigned top;
      longint unsigned m, frac;
      top = 0;
      frac = 0;
      while (top < 40 && (x >> (top + 1)) != 0) top++;
      m = x << (30 - top);
      for (int i = 1; i <= 16; i++) begin
         m = (m * m) >> 30;
         if (m >= (64'd2 << 30)) begin
            m = m >> 1;
            frac = frac | (64'd1 << (16 - i));
         end
      end
      return (longint'(top) << 16) | frac;
   endfunction

   function automatic longint unsigned pair_entropy(longint unsigned k);
      longint unsigned n, s, whole;
      n = ENT_N;
      if (k == 0 || k >= n) return 0;
      s = (k * log2_fix(k) + (n - k) * log2_fix(n - k)) >> ETB;
      whole = longint'(ETB) << 16;
      if (s >= whole) return 0;
      if (whole - s > Q_ONE) return Q_ONE;
      return whole - s;
   endfunction

   task automatic take_solution(int unsigned ps, longint unsigned pop);
      int unsigned s;
      longint unsigned a, b, d, sum, k, adj, dep;
      for (int unsigned i = 0; i + 1 < ps; i++)
         for (int unsigned j = i + 1; j < ps; j++) begin
            s = slot_of(i, j);
            a = genes[i];
            b = genes[j];
            d = a > b ? a - b : b - a;
            sum = adj_sum[s] + d * d;
            if (a < b && order_cnt[s] < 65535) order_cnt[s]++;
            adj_sum[s] = sum > 64'hFFFF_FFFF_FFFF ? 64'hFFFF_FFFF_FFFF : sum;
         end
      if (pop > 1) begin
         for (int unsigned i = 0; i + 1 < ps; i++)
            for (int unsigned j = i + 1; j < ps; j++) begin
               s = slot_of(i, j);
               k = (longint'(order_cnt[s]) << ETB) / pop;
               adj = adj_sum[s] / (pop << 16);
               if (k > ENT_N) k = ENT_N;
               if (adj > Q_ONE) adj = Q_ONE;
               dep = ((Q_ONE - pair_entropy(k)) * (Q_ONE - adj)) >> 16;
               pair_dist[s] = Q_W'(Q_ONE - dep);
               dist_built[s] = 1'b1;
            end
         dists_ready = 1'b1;
      end
   endtask

   task automatic apply_beat(stim_row_type r);
      int unsigned ps, lo, hi;
      dist_rsp_type e;
      ps = active_genes();
      if (r.op == OP_GENE) begin
         if (gene_cnt < ps) begin
            genes[gene_cnt] = r.gene;
            genes_seen[gene_cnt] = 1'b1;
            gene_cnt++;
         end
         if (r.last) begin
            take_solution(ps, r.pop);
            gene_cnt = 0;
         end
      end else begin
         lo = r.a < r.b ? int'(r.a) : int'(r.b);
         hi = r.a < r.b ? int'(r.b) : int'(r.a);
         if (!dists_ready || lo == hi || hi >= ps) begin
            e.distance = '0;
            e.valid = 1'b0;
         end else begin
            e.distance = pair_dist[slot_of(lo, hi)];
            e.valid = 1'b1;
         end
         if (r.fixed) begin
            e.distance = r.fdist;
            e.valid = r.fvalid;
         end
         pending_distances.insert(pending_distances.size(), e);
      end
   endtask

   task automatic send_beat(stim_row_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= r.op;
      req_gene_value <= r.gene;
      req_last_gene <= r.last;
      req_population_size <= r.pop;
      req_first_gene <= r.a;
      req_second_gene <= r.b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_beat(r);
   endtask

   task automatic write_size(logic [PS_W-1:0] v);
      csr_valid <= 1'b1;
      csr_problem_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      size_reg = v;
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   function automatic stim_row_type gene_row(logic [15:0] g, logic last, logic [15:0] pop);
      stim_row_type r;
      r = '{OP_GENE, g, last, pop, 5'd0, 5'd0, 1'b0, '0, 1'b0};
      r.a = 5'($urandom_range(31));
      r.b = 5'($urandom_range(31));
      return r;
   endfunction

   function automatic stim_row_type query_row(logic [4:0] a, logic [4:0] b);
      stim_row_type r;
      r = '{OP_QUERY, 16'h0, 1'b0, 16'h0, a, b, 1'b0, '0, 1'b0};
      r.gene = 16'($urandom);
      r.last = 1'($urandom_range(1));
      r.pop = 16'($urandom);
      return r;
   endfunction

   function automatic logic [15:0] rand_gene();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [15:0] rand_pop();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'hFFFF;
         3, 4, 5: return 16'($urandom_range(2, 12));
         default: return 16'($urandom_range(2, 65535));
      endcase
   endfunction

   task automatic random_phase(int n);
      int sent, ps, len, lo, hi;
      stim_row_type r;
      sent = 0;
      while (sent < n) begin
         ps = active_genes();
         if (sent == n / 2) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_distances.size() != 0) @(posedge clock);
         end
         if ($urandom_range(9) < 3) begin
            if ($urandom_range(9) < 7) begin
               r = query_row(5'($urandom_range(ps - 1)), 5'($urandom_range(ps - 1)));
            end else begin
               r = query_row(5'($urandom_range(31)), 5'($urandom_range(31)));
            end
            lo = r.a < r.b ? int'(r.a) : int'(r.b);
            hi = r.a < r.b ? int'(r.b) : int'(r.a);
            if (dists_ready && lo != hi && hi < ps && !dist_built[slot_of(lo, hi)])
               r.b = r.a;
            send_beat(r);
            sent++;
         end else begin
            len = ps;
            if ($urandom_range(9) == 0) len = ps + $urandom_range(1, 3);
            else if ($urandom_range(9) == 0 && genes_filled(ps))
               len = $urandom_range(1, ps - 1);
            // big sizes rebuild slowly, so keep most of their solutions unrebuilt
            for (int g = 0; g < len; g++) begin
               r = gene_row(rand_gene(), g == len - 1, rand_pop());
               if (ps > 8 && r.last && $urandom_range(9) < 7)
                  r.pop = 16'($urandom_range(1));
               send_beat(r);
               if (g < ps) sent++;
            end
         end
      end
      send_beat(query_row(5'($urandom_range(31)), 5'($urandom_range(31))));
   endtask

   initial begin
      logic [PS_W-1:0] sizes [8];
      sizes = '{6'd2, 6'd0, 6'd5, 6'd63, 6'd7, 6'd1, 6'd32, 6'd4};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_operation <= OP_GENE;
      req_gene_value <= '0;
      req_last_gene <= 1'b0;
      req_population_size <= '0;
      req_first_gene <= '0;
      req_second_gene <= '0;
      csr_valid <= 1'b0;
      csr_problem_size <= '0;
      size_reg = 6'd32;
      gene_cnt = 0;
      genes_seen = '0;
      dists_ready = 1'b0;
      failed = 1'b0;
      for (int i = 0; i < MAX_GENES; i++) genes[i] = '0;
      for (int i = 0; i < PAIRS; i++) begin
         order_cnt[i] = 0;
         adj_sum[i] = 0;
         pair_dist[i] = '0;
         dist_built[i] = 1'b0;
      end
      send_idle = 6;
      recv_idle = 86;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      write_size(6'd3);

      // directed part, problem size 3
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd5, 5'd0, 5'd1, 1'b1, 17'd0, 1'b0});
      add_row('{OP_GENE, 16'h0000, 1'b0, 16'd0, 5'd31, 5'd31, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'hFFFF, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'h8000, 1'b1, 16'd1, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'hFFFF, 1'b1, 16'hFFFF, 5'd1, 5'd0, 1'b1, 17'd0, 1'b0});
      add_row('{OP_GENE, 16'hFFFF, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'h0000, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'h1234, 1'b1, 16'hFFFF, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd1, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd2, 5'd2, 1'b1, 17'd0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd0, 5'd31, 1'b1, 17'd0, 1'b0});
      add_row('{OP_GENE, 16'd1, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'd2, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'd3, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'd4, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'd5, 1'b1, 16'd2, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd0, 5'd2, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd1, 5'd2, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'd7, 1'b1, 16'd3, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd2, 5'd1, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'h0, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'h0, 1'b0, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_GENE, 16'h0, 1'b1, 16'd0, 5'd0, 5'd0, 1'b0, '0, 1'b0});
      add_row('{OP_QUERY, 16'h0, 1'b0, 16'd0, 5'd0, 5'd1, 1'b0, '0, 1'b0});
      foreach (rows[i]) send_beat(rows[i]);
      drain();

      for (int p = 0; p < 8; p++) begin
         if (p == 3) begin
            send_idle = 86;
            recv_idle = 6;
         end else if (p == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         write_size(sizes[p]);
         random_phase(120);
         drain();
      end

      if (!failed)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      dist_rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 300000) begin
            $display("FAILED: results differ");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_distances.size() == 0) begin
               $display("%0t unexpected beat: distance %0d valid %0b", $time,
                        rsp_distance, rsp_distance_valid);
               failed = 1'b1;
            end else begin
               e = pending_distances.pop_front();
               if (rsp_distance !== e.distance) begin
                  $display("%0t distance: expected %0d actual %0d", $time, e.distance,
                           rsp_distance);
                  failed = 1'b1;
               end
               if (rsp_distance_valid !== e.valid) begin
                  $display("%0t distance_valid: expected %0b actual %0b", $time,
                           e.valid, rsp_distance_valid);
                  failed = 1'b1;
               end
            end
         end
      end
   end

endmodule
